[hw/rtl/random_excursion_visit_histogram_top_macros.svh]
// Assertion macros for the random excursion visit histogram block.
`ifndef RANDOM_EXCURSION_VISIT_HISTOGRAM_TOP_MACROS_SVH
`define RANDOM_EXCURSION_VISIT_HISTOGRAM_TOP_MACROS_SVH

// Check a same-cycle implication on the rising clock edge.
`define REVH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define REVH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/revh_pkg.sv]
// Shared constants, types and helpers for the random excursion visit histogram.
package revh_pkg;

   localparam int COUNT_WIDTH      = 20;
   localparam int WALK_WIDTH       = 22;
   localparam int CFG_WIDTH        = 20;
   localparam int N_STATES         = 8;
   localparam int N_BINS           = 6;
   localparam int STATE_W          = 3;
   localparam int VISIT_W          = 3;
   localparam int VISIT_SAT        = 5;
   localparam int CSR_INDEX_W      = 1;
   localparam int MAX_CYCLES_RESET = 10000;
   localparam int MIN_CYCLES_RESET = 500;

   // Register map of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_CYCLES = 1'b0,
      CSR_MIN_CYCLES = 1'b1
   } csr_index_type;

   // Per-item commands from the walk unit to the state lanes
   typedef struct packed {
      logic add_en;    // close the cycle into the histogram
      logic clear_en;  // end of stream, clear everything
   } lane_ctl_type;

   // Status flags that travel with the result bank
   typedef struct packed {
      logic within_limit;
      logic enough;
   } flags_type;

   // Walk position watched by lane s: lanes 0..3 are -4..-1, lanes 4..7 are +1..+4
   function automatic int state_value(input int s);
      int v;
      v = (s < N_STATES / 2) ? s - N_STATES / 2 : s - N_STATES / 2 + 1;
      return v;
   endfunction

endpackage

[hw/rtl/revh_walk.sv]
// Cumulative walk, cycle counter and overflow control.
module revh_walk #(
   parameter int COUNT_WIDTH = revh_pkg::COUNT_WIDTH,
   parameter int WALK_WIDTH  = revh_pkg::WALK_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 bit_value,
   input  logic                                 is_last,
   input  logic [revh_pkg::CFG_WIDTH-1:0]       max_cycles,
   input  logic [revh_pkg::CFG_WIDTH-1:0]       min_cycles,
   output logic [revh_pkg::N_STATES-1:0]        hit,
   output revh_pkg::lane_ctl_type               lane_ctl,
   output logic [COUNT_WIDTH-1:0]               cycle_total,
   output revh_pkg::flags_type                  flags
);

   localparam int CYC_W = COUNT_WIDTH + 1;
   localparam int CMP_W = (CYC_W > revh_pkg::CFG_WIDTH) ? CYC_W : revh_pkg::CFG_WIDTH;
   localparam logic signed [WALK_WIDTH-1:0] WALK_HI = {1'b0, {(WALK_WIDTH-1){1'b1}}};
   localparam logic signed [WALK_WIDTH-1:0] WALK_LO = {1'b1, {(WALK_WIDTH-1){1'b0}}};

   logic signed [WALK_WIDTH-1:0] walk_ff, walk_in, walk_upd;
   logic [CYC_W-1:0]             cyc_ff, cyc_in, cyc_upd;
   logic                         ovf_ff, ovf_in, ovf_upd;
   logic                         active, at_zero, close;
   logic [CMP_W-1:0]             cyc_ext, max_ext, min_ext;

   // Step the walk with saturation at the signed limits
   always_comb begin
      active   = advance && !ovf_ff;
      walk_upd = walk_ff;
      if (active) begin
         if (bit_value) begin
            if (walk_ff != WALK_HI) walk_upd = walk_ff + WALK_WIDTH'(1);
         end else begin
            if (walk_ff != WALK_LO) walk_upd = walk_ff - WALK_WIDTH'(1);
         end
      end
      at_zero = (walk_upd == '0);
   end

   // Flag the lane whose state the walk lands on
   for (genvar s = 0; s < revh_pkg::N_STATES; s++) begin : g_hit
      localparam logic signed [WALK_WIDTH-1:0] STATE_POS =
         WALK_WIDTH'(revh_pkg::state_value(s));
      assign hit[s] = active && (walk_upd == STATE_POS);
   end

   // Count closed cycles and raise overflow past the limit
   always_comb begin
      close   = active && (at_zero || is_last);
      cyc_upd = cyc_ff;
      if (close && (cyc_ff != '1)) cyc_upd = cyc_ff + CYC_W'(1);
      cyc_ext = CMP_W'(cyc_upd);
      max_ext = CMP_W'(max_cycles);
      min_ext = CMP_W'(min_cycles);
      ovf_upd = ovf_ff || (close && (cyc_ext > max_ext));
      lane_ctl.add_en   = active && (at_zero ? !ovf_upd : is_last);
      lane_ctl.clear_en = advance && is_last;
   end

   // Report the totals as they stand after this item
   always_comb begin
      cycle_total        = (cyc_upd[CYC_W-1]) ? '1 : cyc_upd[COUNT_WIDTH-1:0];
      flags.within_limit = !ovf_upd;
      flags.enough       = (cyc_ext >= min_ext);
   end

   // Clear stream state after the last bit
   always_comb begin
      walk_in = lane_ctl.clear_en ? '0 : walk_upd;
      cyc_in  = lane_ctl.clear_en ? '0 : cyc_upd;
      ovf_in  = lane_ctl.clear_en ? 1'b0 : ovf_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
         cyc_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         walk_ff <= walk_in;
         cyc_ff  <= cyc_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

[hw/rtl/revh_lane.sv]
// One walk state: visit counter and its six histogram cells.
module revh_lane #(
   parameter int COUNT_WIDTH = revh_pkg::COUNT_WIDTH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        hit,
   input  revh_pkg::lane_ctl_type                      lane_ctl,
   output logic [revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0] snap
);

   localparam int VW = revh_pkg::VISIT_W;

   logic [VW-1:0]                                 vc_ff, vc_in, vc_upd;
   logic [revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0]  cell_ff, cell_in, cell_upd;

   // Count visits, saturating
   always_comb begin
      vc_upd = vc_ff;
      if (hit && (vc_ff < VW'(revh_pkg::VISIT_SAT))) vc_upd = vc_ff + VW'(1);
   end

   // Bump the cell picked by the visit count when the cycle closes
   always_comb begin
      for (int b = 0; b < revh_pkg::N_BINS; b++) begin
         cell_upd[b] = cell_ff[b];
         if (lane_ctl.add_en && (vc_upd == VW'(b)) && (cell_ff[b] != '1))
            cell_upd[b] = cell_ff[b] + COUNT_WIDTH'(1);
      end
      vc_in   = (lane_ctl.clear_en || lane_ctl.add_en) ? '0 : vc_upd;
      cell_in = lane_ctl.clear_en ? '0 : cell_upd;
      snap    = cell_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff   <= '0;
         cell_ff <= '0;
      end else begin
         vc_ff   <= vc_in;
         cell_ff <= cell_in;
      end
   end

endmodule

[hw/rtl/revh_drain.sv]
// Result bank: holds a finished histogram and sends it out one state per transfer.
module revh_drain #(
   parameter int COUNT_WIDTH = revh_pkg::COUNT_WIDTH
) (
   input  logic                                                        clock,
   input  logic                                                        reset,
   input  logic                                                        load,
   input  logic [revh_pkg::N_STATES-1:0][revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0] snap,
   input  logic [COUNT_WIDTH-1:0]                                      cycle_total,
   input  revh_pkg::flags_type                                         flags,
   output logic                                                        busy,
   output logic                                                        rsp_valid,
   input  logic                                                        rsp_ready,
   output logic [revh_pkg::STATE_W-1:0]                                rsp_state_index,
   output logic [revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0]                rsp_counts,
   output logic [COUNT_WIDTH-1:0]                                      rsp_cycle_total,
   output logic                                                        rsp_cycles_within_limit,
   output logic                                                        rsp_enough_cycles,
   output logic                                                        rsp_final_result
);

   localparam int SW = revh_pkg::STATE_W;
   localparam logic [SW-1:0] LAST_IDX = SW'(revh_pkg::N_STATES - 1);

   logic [revh_pkg::N_STATES-1:0][revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0] bank_ff, bank_in;
   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   revh_pkg::flags_type     flags_ff, flags_in;
   logic [SW-1:0]           idx_ff, idx_in;
   logic                    busy_ff, busy_in;
   logic                    xfer, done;

   always_comb begin
      xfer = busy_ff && rsp_ready;
      done = xfer && (idx_ff == LAST_IDX);
   end

   // Load a new bank or advance to the next state on a transfer
   always_comb begin
      bank_in  = bank_ff;
      total_in = total_ff;
      flags_in = flags_ff;
      if (load) begin
         bank_in  = snap;
         total_in = cycle_total;
         flags_in = flags;
      end else if (xfer) begin
         for (int i = 0; i < revh_pkg::N_STATES - 1; i++) bank_in[i] = bank_ff[i+1];
         bank_in[revh_pkg::N_STATES-1] = '0;
      end
      busy_in = load ? 1'b1 : (done ? 1'b0 : busy_ff);
      idx_in  = load ? '0 : (xfer ? idx_ff + SW'(1) : idx_ff);
   end

   always_ff @(posedge clock) begin
      bank_ff  <= bank_in;
      total_ff <= total_in;
      flags_ff <= flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Drive the result channel from the head of the bank
   always_comb begin
      busy                    = busy_ff;
      rsp_valid               = busy_ff;
      rsp_state_index         = idx_ff;
      rsp_counts              = bank_ff[0];
      rsp_cycle_total         = total_ff;
      rsp_cycles_within_limit = flags_ff.within_limit;
      rsp_enough_cycles       = flags_ff.enough;
      rsp_final_result        = (idx_ff == LAST_IDX);
   end

endmodule

[hw/rtl/random_excursion_visit_histogram_top.sv]
// Top level of the random excursion visit histogram block.
// Throughput: one bit per cycle unless a last bit waits; the walk steps from the input register.
// Results: once the last bit leaves the input register, its histogram loads the single-entry
// result bank, which sends the eight results, one per cycle while rsp_ready is high.
// A last bit waits in the input register while the previous eight results still drain.
// Reset (synchronous): clears walk, counts, histogram and flags; max_cycles 10000, min_cycles 500.
`include "random_excursion_visit_histogram_top_macros.svh"
module random_excursion_visit_histogram_top #(
   parameter int COUNT_WIDTH = revh_pkg::COUNT_WIDTH,
   parameter int WALK_WIDTH  = revh_pkg::WALK_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_bit_value,
   input  logic                                 req_is_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [revh_pkg::STATE_W-1:0]         rsp_state_index,
   output logic [COUNT_WIDTH-1:0]               rsp_visits_zero,
   output logic [COUNT_WIDTH-1:0]               rsp_visits_one,
   output logic [COUNT_WIDTH-1:0]               rsp_visits_two,
   output logic [COUNT_WIDTH-1:0]               rsp_visits_three,
   output logic [COUNT_WIDTH-1:0]               rsp_visits_four,
   output logic [COUNT_WIDTH-1:0]               rsp_visits_five_plus,
   output logic [COUNT_WIDTH-1:0]               rsp_cycle_total,
   output logic                                 rsp_cycles_within_limit,
   output logic                                 rsp_enough_cycles,
   output logic                                 rsp_final_result,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [revh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [revh_pkg::CFG_WIDTH-1:0]       csr_data
);

   localparam int CW = revh_pkg::CFG_WIDTH;

   logic [CW-1:0]  max_cycles_ff, max_cycles_in, min_cycles_ff, min_cycles_in;
   logic           in_valid_ff, in_valid_in, in_bit_ff, in_bit_in, in_last_ff, in_last_in;
   logic           advance, drain_busy, drain_load;
   logic [revh_pkg::N_STATES-1:0]      hit;
   revh_pkg::lane_ctl_type             lane_ctl;
   logic [COUNT_WIDTH-1:0]             cycle_total;
   revh_pkg::flags_type                flags;
   logic [revh_pkg::N_STATES-1:0][revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0] snap;
   logic [revh_pkg::N_BINS-1:0][COUNT_WIDTH-1:0]                        rsp_counts;

   // Configuration registers, always ready
   always_comb begin
      csr_ready     = 1'b1;
      max_cycles_in = max_cycles_ff;
      min_cycles_in = min_cycles_ff;
      if (csr_valid) begin
         case (revh_pkg::csr_index_type'(csr_index))
            revh_pkg::CSR_MAX_CYCLES: max_cycles_in = csr_data;
            revh_pkg::CSR_MIN_CYCLES: min_cycles_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cycles_ff <= CW'(revh_pkg::MAX_CYCLES_RESET);
         min_cycles_ff <= CW'(revh_pkg::MIN_CYCLES_RESET);
      end else begin
         max_cycles_ff <= max_cycles_in;
         min_cycles_ff <= min_cycles_in;
      end
   end

   // Input register; hold a last bit until the result bank is free
   always_comb begin
      advance     = in_valid_ff && !(in_last_ff && drain_busy);
      req_ready   = !in_valid_ff || advance;
      drain_load  = advance && in_last_ff;
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      in_bit_in   = (req_ready && req_valid) ? req_bit_value : in_bit_ff;
      in_last_in  = (req_ready && req_valid) ? req_is_last : in_last_ff;
   end

   always_ff @(posedge clock) begin
      in_bit_ff  <= in_bit_in;
      in_last_ff <= in_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   revh_walk #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .WALK_WIDTH  (WALK_WIDTH)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .bit_value   (in_bit_ff),
      .is_last     (in_last_ff),
      .max_cycles  (max_cycles_ff),
      .min_cycles  (min_cycles_ff),
      .hit         (hit),
      .lane_ctl    (lane_ctl),
      .cycle_total (cycle_total),
      .flags       (flags)
   );

   for (genvar s = 0; s < revh_pkg::N_STATES; s++) begin : g_lane
      revh_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .hit      (hit[s]),
         .lane_ctl (lane_ctl),
         .snap     (snap[s])
      );
   end

   revh_drain #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_drain (
      .clock                   (clock),
      .reset                   (reset),
      .load                    (drain_load),
      .snap                    (snap),
      .cycle_total             (cycle_total),
      .flags                   (flags),
      .busy                    (drain_busy),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_state_index         (rsp_state_index),
      .rsp_counts              (rsp_counts),
      .rsp_cycle_total         (rsp_cycle_total),
      .rsp_cycles_within_limit (rsp_cycles_within_limit),
      .rsp_enough_cycles       (rsp_enough_cycles),
      .rsp_final_result        (rsp_final_result)
   );

   // Split the bank head into the six count fields
   always_comb begin
      rsp_visits_zero      = rsp_counts[0];
      rsp_visits_one       = rsp_counts[1];
      rsp_visits_two       = rsp_counts[2];
      rsp_visits_three     = rsp_counts[3];
      rsp_visits_four      = rsp_counts[4];
      rsp_visits_five_plus = rsp_counts[5];
   end

   // A stream end never overwrites results still draining
   `REVH_ASSERT_NOW(a_load_when_free, clock, reset, drain_load, !rsp_valid,
      "result bank loaded while busy")
   // After the eighth transfer the channel is quiet in the next cycle
   `REVH_ASSERT_NEXT(a_quiet_after_final, clock, reset,
      rsp_valid && rsp_ready && rsp_final_result, !rsp_valid,
      "result valid right after final transfer")
   // Results of a run follow one another without a gap in the index
   `REVH_ASSERT_NEXT(a_index_steps, clock, reset,
      rsp_valid && rsp_ready && !rsp_final_result,
      rsp_valid && (rsp_state_index == $past(rsp_state_index) + 3'd1),
      "result index did not advance by one")

endmodule
